FILE: hdl/pwam_pkg.sv
// pwam_pkg: shared types, register indexes, reset values and helper functions
// for the pacer with apd measurement block; depends on nothing
`default_nettype none

package pwam_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_JUNCTION_OFFSET    = 3'd0;
    localparam logic [2:0] REG_BEAT_PERIOD_TICKS  = 3'd1;
    localparam logic [2:0] REG_STIM_LEN_TICKS     = 3'd2;
    localparam logic [2:0] REG_STIM_AMPLITUDE     = 3'd3;
    localparam logic [2:0] REG_UPSTROKE_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_REPOL_PERCENT      = 3'd5;
    localparam logic [2:0] REG_STIM_WINDOW_TICKS  = 3'd6;
    localparam logic [2:0] REG_PEAK_HOLD_TICKS    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register reset values
    localparam logic [15:0] RST_JUNCTION_OFFSET    = 16'd0;
    localparam logic [19:0] RST_BEAT_PERIOD_TICKS  = 20'd10000;
    localparam logic [19:0] RST_STIM_LEN_TICKS     = 20'd10;
    localparam logic [15:0] RST_STIM_AMPLITUDE     = 16'd4000;
    localparam logic [15:0] RST_UPSTROKE_THRESHOLD = 16'hF060; // -4000
    localparam logic [6:0]  RST_REPOL_PERCENT      = 7'd90;
    localparam logic [19:0] RST_STIM_WINDOW_TICKS  = 20'd40;
    localparam logic [19:0] RST_PEAK_HOLD_TICKS    = 20'd50;

    // input function codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // measure_phase codes on the result
    localparam logic [1:0] MP_WAIT_UP    = 2'd0;
    localparam logic [1:0] MP_PEAK       = 2'd1;
    localparam logic [1:0] MP_WAIT_REPOL = 2'd2;
    localparam logic [1:0] MP_DONE       = 2'd3;

    // floor(m / 100) = (m * PCT_RECIP) >> PCT_SHIFT, exact for m < 2^23
    localparam int          PCT_MAG_W = 23;
    localparam int          PCT_SHIFT = 30;
    localparam logic [23:0] PCT_RECIP = 24'd10737419;

    localparam logic [31:0] TICK_RESET = 32'hFFFF_FFFF;
    localparam logic [19:0] APD_MAX    = 20'hF_FFFF;

    typedef struct packed {
        logic [15:0] junction_offset;
        logic [19:0] beat_period_ticks;
        logic [19:0] stim_len_ticks;
        logic [15:0] stim_amplitude;
        logic [15:0] upstroke_threshold;
        logic [6:0]  repol_percent;
        logic [19:0] stim_window_ticks;
        logic [19:0] peak_hold_ticks;
    } t_cfg;

    // pacer view of the tick being processed, new-state values
    typedef struct packed {
        logic        restart;
        logic        beat;
        logic        stim;
        logic [31:0] tick;
        logic [15:0] beats;
        logic [15:0] rest;
        logic [15:0] rest_q;
    } t_pace;

    typedef enum logic [3:0] {
        PH_WAIT_UP    = 4'b0001,
        PH_PEAK       = 4'b0010,
        PH_WAIT_REPOL = 4'b0100,
        PH_DONE       = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        RP_IDLE = 3'b001,
        RP_MUL  = 3'b010,
        RP_DIV  = 3'b100
    } t_rp_state;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] res;
        if (v > 19'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -19'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_WAIT_UP:    code = MP_WAIT_UP;
            PH_PEAK:       code = MP_PEAK;
            PH_WAIT_REPOL: code = MP_WAIT_REPOL;
            PH_DONE:       code = MP_DONE;
            default:       code = MP_WAIT_UP;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pwam_cfg.sv
// pwam_cfg: configuration register file for the pacer with apd measurement
// depends on pwam_pkg
`default_nettype none

module pwam_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pwam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pwam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pwam_pkg::t_cfg                      o_cfg
);

    pwam_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.junction_offset    <= pwam_pkg::RST_JUNCTION_OFFSET;
            r_cfg.beat_period_ticks  <= pwam_pkg::RST_BEAT_PERIOD_TICKS;
            r_cfg.stim_len_ticks     <= pwam_pkg::RST_STIM_LEN_TICKS;
            r_cfg.stim_amplitude     <= pwam_pkg::RST_STIM_AMPLITUDE;
            r_cfg.upstroke_threshold <= pwam_pkg::RST_UPSTROKE_THRESHOLD;
            r_cfg.repol_percent      <= pwam_pkg::RST_REPOL_PERCENT;
            r_cfg.stim_window_ticks  <= pwam_pkg::RST_STIM_WINDOW_TICKS;
            r_cfg.peak_hold_ticks    <= pwam_pkg::RST_PEAK_HOLD_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pwam_pkg::REG_JUNCTION_OFFSET:    r_cfg.junction_offset    <= i_cfg_data[15:0];
                pwam_pkg::REG_BEAT_PERIOD_TICKS:  r_cfg.beat_period_ticks  <= i_cfg_data;
                pwam_pkg::REG_STIM_LEN_TICKS:     r_cfg.stim_len_ticks     <= i_cfg_data;
                pwam_pkg::REG_STIM_AMPLITUDE:     r_cfg.stim_amplitude     <= i_cfg_data[15:0];
                pwam_pkg::REG_UPSTROKE_THRESHOLD: r_cfg.upstroke_threshold <= i_cfg_data[15:0];
                pwam_pkg::REG_REPOL_PERCENT:      r_cfg.repol_percent      <= i_cfg_data[6:0];
                pwam_pkg::REG_STIM_WINDOW_TICKS:  r_cfg.stim_window_ticks  <= i_cfg_data;
                pwam_pkg::REG_PEAK_HOLD_TICKS:    r_cfg.peak_hold_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pwam_pacer.sv
// pwam_pacer: tick counter, beat timing, stimulus gate and rest voltage latch
// depends on pwam_pkg
`default_nettype none

module pwam_pacer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic           i_func,
    input  wire logic [15:0]    i_volt,
    input  pwam_pkg::t_cfg      i_cfg,
    output pwam_pkg::t_pace     o_pace
);

    logic [31:0] r_tick, n_tick;
    logic [31:0] r_cycle_start, n_cycle_start;
    logic [15:0] r_beats, n_beats;
    logic [15:0] r_rest, n_rest;

    logic [31:0] tick_inc;
    logic [31:0] elapsed;
    logic [31:0] since_start;
    logic        restart;
    logic        beat;
    logic        stim;

    always_comb begin
        restart     = (i_func == pwam_pkg::FUNC_RESTART);
        tick_inc    = r_tick + 32'd1;
        elapsed     = tick_inc - r_cycle_start;
        beat        = !restart && (elapsed >= {12'd0, i_cfg.beat_period_ticks});
        since_start = beat ? 32'd0 : elapsed;
        stim        = !restart && (since_start < {12'd0, i_cfg.stim_len_ticks});

        if (restart) begin
            n_tick        = pwam_pkg::TICK_RESET;
            n_cycle_start = 32'd0;
            n_beats       = 16'd1;
            n_rest        = i_volt;
        end else begin
            n_tick        = tick_inc;
            n_cycle_start = beat ? tick_inc : r_cycle_start;
            n_beats       = beat ? r_beats + 16'd1 : r_beats;
            n_rest        = beat ? i_volt : r_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= pwam_pkg::TICK_RESET;
            r_cycle_start <= 32'd0;
            r_beats       <= 16'd1;
            r_rest        <= 16'd0;
        end else if (i_step) begin
            r_tick        <= n_tick;
            r_cycle_start <= n_cycle_start;
            r_beats       <= n_beats;
            r_rest        <= n_rest;
        end
    end

    always_comb begin
        o_pace.restart = restart;
        o_pace.beat    = beat;
        o_pace.stim    = stim;
        o_pace.tick    = n_tick;
        o_pace.beats   = n_beats;
        o_pace.rest    = n_rest;
        o_pace.rest_q  = r_rest;
    end

endmodule

`default_nettype wire

FILE: hdl/pwam_apd.sv
// pwam_apd: apd phase sequencer with a multiply-then-divide repolarisation level unit
// depends on pwam_pkg
`default_nettype none

module pwam_apd (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [15:0]    i_volt,
    input  pwam_pkg::t_pace     i_pace,
    input  pwam_pkg::t_cfg      i_cfg,
    output logic [1:0]          o_phase_code,
    output logic [19:0]         o_apd,
    output logic                o_busy
);

    pwam_pkg::t_phase    r_phase, n_phase;
    pwam_pkg::t_phase    phase_cur;
    pwam_pkg::t_rp_state r_rp_state, n_rp_state;

    logic [31:0] r_upstroke, n_upstroke;
    logic [15:0] r_peak, n_peak;
    logic [31:0] r_peak_tick, n_peak_tick;
    logic [15:0] r_repol;
    logic [19:0] r_apd, n_apd;
    logic [pwam_pkg::PCT_MAG_W-1:0] r_mag;
    logic        r_neg;

    logic [31:0] up_age;
    logic [31:0] peak_age;
    logic        start;

    // repolarisation level datapath
    logic signed [16:0] amp;
    logic signed [24:0] prod;
    logic [24:0]        prod_mag;
    logic [46:0]        quot_full;
    logic [16:0]        quot;
    logic signed [18:0] drop;
    logic signed [18:0] repol_wide;

    always_comb begin
        phase_cur   = i_pace.beat ? pwam_pkg::PH_WAIT_UP : r_phase;
        up_age      = i_pace.tick - r_upstroke;
        peak_age    = i_pace.tick - r_peak_tick;
        n_phase     = phase_cur;
        n_upstroke  = r_upstroke;
        n_peak      = r_peak;
        n_peak_tick = r_peak_tick;
        n_apd       = r_apd;
        start       = 1'b0;

        if (i_pace.restart) begin
            n_phase = pwam_pkg::PH_WAIT_UP;
        end else begin
            unique case (phase_cur)
                pwam_pkg::PH_WAIT_UP: begin
                    if ($signed(i_volt) >= $signed(i_cfg.upstroke_threshold)) begin
                        n_upstroke  = i_pace.tick;
                        n_peak      = i_pace.rest;
                        n_peak_tick = i_pace.tick;
                        n_phase     = pwam_pkg::PH_PEAK;
                    end
                end
                pwam_pkg::PH_PEAK: begin
                    if (up_age > {12'd0, i_cfg.stim_window_ticks}) begin
                        if ($signed(r_peak) < $signed(i_volt)) begin
                            n_peak      = i_volt;
                            n_peak_tick = i_pace.tick;
                        end else if (peak_age > {12'd0, i_cfg.peak_hold_ticks}) begin
                            n_phase = pwam_pkg::PH_WAIT_REPOL;
                            start   = 1'b1;
                        end
                    end
                end
                pwam_pkg::PH_WAIT_REPOL: begin
                    if ($signed(i_volt) <= $signed(r_repol)) begin
                        n_apd   = (|up_age[31:20]) ? pwam_pkg::APD_MAX : up_age[19:0];
                        n_phase = pwam_pkg::PH_DONE;
                    end
                end
                pwam_pkg::PH_DONE: ;
                default: n_phase = pwam_pkg::PH_WAIT_UP;
            endcase
        end
    end

    // peak and rest stay frozen while the unit runs: no item moves meanwhile
    always_comb begin
        amp       = $signed({r_peak[15], r_peak}) - $signed({i_pace.rest_q[15], i_pace.rest_q});
        prod      = amp * $signed({1'b0, i_cfg.repol_percent});
        prod_mag  = prod[24] ? 25'(-prod) : prod;
        quot_full = 47'(r_mag) * 47'(pwam_pkg::PCT_RECIP);
        quot      = quot_full[46:pwam_pkg::PCT_SHIFT];
        drop      = r_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        repol_wide = $signed({{3{r_peak[15]}}, r_peak}) - drop;
    end

    always_comb begin
        n_rp_state = r_rp_state;
        unique case (r_rp_state)
            pwam_pkg::RP_IDLE: if (i_step && start) n_rp_state = pwam_pkg::RP_MUL;
            pwam_pkg::RP_MUL:  n_rp_state = pwam_pkg::RP_DIV;
            pwam_pkg::RP_DIV:  n_rp_state = pwam_pkg::RP_IDLE;
            default:           n_rp_state = pwam_pkg::RP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pwam_pkg::PH_WAIT_UP;
            r_rp_state  <= pwam_pkg::RP_IDLE;
            r_upstroke  <= 32'd0;
            r_peak      <= 16'd0;
            r_peak_tick <= 32'd0;
            r_repol     <= 16'd0;
            r_apd       <= 20'd0;
        end else begin
            r_rp_state <= n_rp_state;
            if (i_step) begin
                r_phase     <= n_phase;
                r_upstroke  <= n_upstroke;
                r_peak      <= n_peak;
                r_peak_tick <= n_peak_tick;
                r_apd       <= n_apd;
            end
            if (r_rp_state == pwam_pkg::RP_DIV) begin
                r_repol <= pwam_pkg::sat16(repol_wide);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rp_state == pwam_pkg::RP_MUL) begin
            r_mag <= prod_mag[pwam_pkg::PCT_MAG_W-1:0];
            r_neg <= prod[24];
        end
    end

    assign o_phase_code = pwam_pkg::phase_code(n_phase);
    assign o_apd        = n_apd;
    assign o_busy       = (r_rp_state != pwam_pkg::RP_IDLE);

endmodule

`default_nettype wire

FILE: hdl/pacer_with_apd_measure_unit.sv
// pacer_with_apd_measure_unit: pacing, stimulus gating and apd measurement per tick
// flow: an accepted item waits in the input register, then moves to the result register
// throughput: one item per cycle while the receiver keeps up; the item that ends the
//   peak search starts the repolarisation level unit (one multiply stage, one
//   reciprocal divide stage) and the next item waits for it, at most once per beat or restart
// reset: i_rst_n synchronous active low, restores register defaults and state
`default_nettype none

module pacer_with_apd_measure_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pwam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pwam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_func,
    input  wire logic signed [15:0]              i_voltage_sample,
    // result item channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [15:0]                          o_stim_current,
    output logic                                 o_stim_active,
    output logic [15:0]                          o_beat_count,
    output logic [19:0]                          o_apd_ticks,
    output logic [1:0]                           o_measure_phase,
    output logic signed [15:0]                   o_membrane_voltage
);

    pwam_pkg::t_cfg  w_cfg;
    pwam_pkg::t_pace w_pace;

    // input register: one item, voltage already offset-corrected
    logic        r_in_valid;
    logic        r_in_func;
    logic [15:0] r_in_volt;

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_stim_current;
    logic        r_out_stim_active;
    logic [15:0] r_out_beat_count;
    logic [19:0] r_out_apd;
    logic [1:0]  r_out_phase;
    logic [15:0] r_out_volt;

    logic        w_accept;
    logic        w_move;
    logic        w_busy;
    logic [15:0] w_volt_corr;
    logic [1:0]  w_phase_code;
    logic [19:0] w_apd;

    pwam_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // offset removal happens on the way into the input register
    assign w_volt_corr = pwam_pkg::sat16(
        $signed({{3{i_voltage_sample[15]}}, i_voltage_sample})
        - $signed({{3{w_cfg.junction_offset[15]}}, w_cfg.junction_offset}));

    // the item in the input register advances into the result register when
    // the result slot is free or being drained and the repol unit is idle
    assign w_move   = r_in_valid && !w_busy && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || w_move;
    assign w_accept = i_valid && o_ready;

    pwam_pacer u_pacer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_move),
        .i_func  (r_in_func),
        .i_volt  (r_in_volt),
        .i_cfg   (w_cfg),
        .o_pace  (w_pace)
    );

    pwam_apd u_apd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_move),
        .i_volt       (r_in_volt),
        .i_pace       (w_pace),
        .i_cfg        (w_cfg),
        .o_phase_code (w_phase_code),
        .o_apd        (w_apd),
        .o_busy       (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_func <= i_func;
            r_in_volt <= w_volt_corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_stim_current <= w_pace.stim ? w_cfg.stim_amplitude : 16'd0;
            r_out_stim_active  <= w_pace.stim;
            r_out_beat_count   <= w_pace.beats;
            r_out_apd          <= w_apd;
            r_out_phase        <= w_phase_code;
            r_out_volt         <= r_in_volt;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_stim_current     = r_out_stim_current;
    assign o_stim_active      = r_out_stim_active;
    assign o_beat_count       = r_out_beat_count;
    assign o_apd_ticks        = r_out_apd;
    assign o_measure_phase    = r_out_phase;
    assign o_membrane_voltage = r_out_volt;

    // no stimulus current is reported without the stimulus flag
    a_stim_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_stim_active |-> o_stim_current == 16'd0)
        else $error("stimulus current without stimulus flag");

    // the repol unit only starts behind an item that entered repolarisation wait
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_busy) |-> $past(w_move) && o_measure_phase == pwam_pkg::MP_WAIT_REPOL)
        else $error("repol unit started without a phase change");

    // the repol unit holds the input side through its multiply and divide states, then releases it
    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_busy) |=> w_busy ##1 !w_busy)
        else $error("repol unit stall length wrong");

endmodule

`default_nettype wire

FILE: verif/pacer_with_apd_measure_unit_tb.sv
// pacer_with_apd_measure_unit_tb: self-checking bench for the pacer and apd measurement unit
// drives shaped action potentials, noise and restarts under random idling, and checks
// every result item against a cycle-free predictor; depends on pwam_pkg and the unit

// one result item, one field per output port
typedef struct packed {
    logic [15:0] stim_current;
    logic        stim_active;
    logic [15:0] beat_count;
    logic [19:0] apd_ticks;
    logic [1:0]  measure_phase;
    logic [15:0] membrane_voltage;
} apd_result_t;

// predicts pacing and apd state per item and checks the result stream in order
class pacer_scoreboard;
    pwam_pkg::t_cfg cfg;
    logic [31:0]    tick_count, cycle_start, upstroke_tick, peak_tick;
    logic [19:0]    last_apd;
    logic [15:0]    beats;
    logic [1:0]     phase;
    int             rest_mv, peak_mv, repol_mv;
    apd_result_t    expected_readouts[$];
    int             fault_count;
    int             readouts_seen;
    int             samples_noted;

    function new();
        cfg.junction_offset    = pwam_pkg::RST_JUNCTION_OFFSET;
        cfg.beat_period_ticks  = pwam_pkg::RST_BEAT_PERIOD_TICKS;
        cfg.stim_len_ticks     = pwam_pkg::RST_STIM_LEN_TICKS;
        cfg.stim_amplitude     = pwam_pkg::RST_STIM_AMPLITUDE;
        cfg.upstroke_threshold = pwam_pkg::RST_UPSTROKE_THRESHOLD;
        cfg.repol_percent      = pwam_pkg::RST_REPOL_PERCENT;
        cfg.stim_window_ticks  = pwam_pkg::RST_STIM_WINDOW_TICKS;
        cfg.peak_hold_ticks    = pwam_pkg::RST_PEAK_HOLD_TICKS;
        tick_count    = pwam_pkg::TICK_RESET;
        cycle_start   = '0;
        upstroke_tick = '0;
        peak_tick     = '0;
        last_apd      = '0;
        beats         = 16'd1;
        phase         = pwam_pkg::MP_WAIT_UP;
        rest_mv       = 0;
        peak_mv       = 0;
        repol_mv      = 0;
        fault_count   = 0;
        readouts_seen = 0;
        samples_noted = 0;
    endfunction

    function int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function int pending();
        return expected_readouts.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] data);
        case (idx)
            pwam_pkg::REG_JUNCTION_OFFSET:    cfg.junction_offset    = data[15:0];
            pwam_pkg::REG_BEAT_PERIOD_TICKS:  cfg.beat_period_ticks  = data;
            pwam_pkg::REG_STIM_LEN_TICKS:     cfg.stim_len_ticks     = data;
            pwam_pkg::REG_STIM_AMPLITUDE:     cfg.stim_amplitude     = data[15:0];
            pwam_pkg::REG_UPSTROKE_THRESHOLD: cfg.upstroke_threshold = data[15:0];
            pwam_pkg::REG_REPOL_PERCENT:      cfg.repol_percent      = data[6:0];
            pwam_pkg::REG_STIM_WINDOW_TICKS:  cfg.stim_window_ticks  = data;
            pwam_pkg::REG_PEAK_HOLD_TICKS:    cfg.peak_hold_ticks    = data;
            default: ;
        endcase
    endfunction

    // advance the pacer and the apd phases by one accepted item
    function void note_sample(logic func, logic [15:0] raw);
        int          s_in, s_off, thr, volt, amp, pct, drop;
        logic [31:0] since_beat, span;
        logic        stim;
        apd_result_t r;
        s_in  = $signed(raw);
        s_off = $signed(cfg.junction_offset);
        thr   = $signed(cfg.upstroke_threshold);
        pct   = cfg.repol_percent;
        volt  = clamp16(s_in - s_off);
        stim  = 1'b0;
        samples_noted++;
        if (func == pwam_pkg::FUNC_RESTART) begin
            tick_count  = pwam_pkg::TICK_RESET;
            cycle_start = '0;
            beats       = 16'd1;
            rest_mv     = volt;
            phase       = pwam_pkg::MP_WAIT_UP;
        end else begin
            tick_count = tick_count + 32'd1;
            since_beat = tick_count - cycle_start;
            if (since_beat >= {12'd0, cfg.beat_period_ticks}) begin
                beats       = beats + 16'd1;
                cycle_start = tick_count;
                rest_mv     = volt;
                phase       = pwam_pkg::MP_WAIT_UP;
            end
            since_beat = tick_count - cycle_start;
            stim = since_beat < {12'd0, cfg.stim_len_ticks};
            case (phase)
                pwam_pkg::MP_WAIT_UP: begin
                    if (volt >= thr) begin
                        upstroke_tick = tick_count;
                        peak_mv       = rest_mv;
                        peak_tick     = tick_count;
                        phase         = pwam_pkg::MP_PEAK;
                    end
                end
                pwam_pkg::MP_PEAK: begin
                    if (tick_count - upstroke_tick > {12'd0, cfg.stim_window_ticks}) begin
                        if (peak_mv < volt) begin
                            peak_mv   = volt;
                            peak_tick = tick_count;
                        end else if (tick_count - peak_tick > {12'd0, cfg.peak_hold_ticks}) begin
                            amp      = peak_mv - rest_mv;
                            drop     = (amp * pct) / 100;
                            repol_mv = clamp16(peak_mv - drop);
                            phase    = pwam_pkg::MP_WAIT_REPOL;
                        end
                    end
                end
                pwam_pkg::MP_WAIT_REPOL: begin
                    if (volt <= repol_mv) begin
                        span     = tick_count - upstroke_tick;
                        last_apd = (span > 32'h000F_FFFF) ? pwam_pkg::APD_MAX : span[19:0];
                        phase    = pwam_pkg::MP_DONE;
                    end
                end
                default: ;
            endcase
        end
        r.stim_current     = stim ? cfg.stim_amplitude : 16'd0;
        r.stim_active      = stim;
        r.beat_count       = beats;
        r.apd_ticks        = last_apd;
        r.measure_phase    = phase;
        r.membrane_voltage = volt[15:0];
        expected_readouts.push_back(r);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
        fault_count++;
        if (fault_count <= 10)
            $display("readout %0d: %s expected 0x%0h, got 0x%0h",
                     readouts_seen, field, want, got);
    endfunction

    function void check_readout(apd_result_t got);
        apd_result_t want;
        readouts_seen++;
        if (expected_readouts.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
                $display("readout %0d arrived with nothing expected", readouts_seen);
            return;
        end
        want = expected_readouts.pop_front();
        if (got.stim_current !== want.stim_current)
            report("stim_current", want.stim_current, got.stim_current);
        if (got.stim_active !== want.stim_active)
            report("stim_active", want.stim_active, got.stim_active);
        if (got.beat_count !== want.beat_count)
            report("beat_count", want.beat_count, got.beat_count);
        if (got.apd_ticks !== want.apd_ticks)
            report("apd_ticks", want.apd_ticks, got.apd_ticks);
        if (got.measure_phase !== want.measure_phase)
            report("measure_phase", want.measure_phase, got.measure_phase);
        if (got.membrane_voltage !== want.membrane_voltage)
            report("membrane_voltage", want.membrane_voltage, got.membrane_voltage);
    endfunction
endclass

module pacer_with_apd_measure_unit_tb;
    import pwam_pkg::*;

    // watchdog: cycles with no handshake on any channel
    localparam int STALL_LIMIT     = 2000;
    // receiver holds off once, after this many items, for this many cycles
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 200;
    // random part: one configuration per phase
    localparam int PHASES          = 7;
    localparam int PHASE_ITEMS     = 135;
    // cycles let pass after the last result before touching registers
    localparam int SETTLE_CYCLES   = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_func;
    logic signed [15:0]    i_voltage_sample;
    logic                  o_valid;
    logic                  i_ready;
    logic [15:0]           o_stim_current;
    logic                  o_stim_active;
    logic [15:0]           o_beat_count;
    logic [19:0]           o_apd_ticks;
    logic [1:0]            o_measure_phase;
    logic signed [15:0]    o_membrane_voltage;

    pacer_with_apd_measure_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_voltage_sample   (i_voltage_sample),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_stim_current     (o_stim_current),
        .o_stim_active      (o_stim_active),
        .o_beat_count       (o_beat_count),
        .o_apd_ticks        (o_apd_ticks),
        .o_measure_phase    (o_measure_phase),
        .o_membrane_voltage (o_membrane_voltage)
    );

    pacer_scoreboard sb;
    t_cfg            cur_cfg;

    // idling intensity per side: 0 none, 1 light, 2 heavy
    int tx_mode = 1;
    int rx_mode = 1;
    int idle_cycles = 0;
    int stall_left = 0;
    int pressure_left = 0;
    int rx_cycles = 0;
    bit pressure_done = 1'b0;

    // action potential shaper, aligned to the beat period where that is practical
    int gen_pos = 0;
    int gen_len = 150;
    int ap_rest, ap_up, ap_peak, ap_plateau, ap_decay;
    bit ap_silent;

    always #10 i_clk = ~i_clk;

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(int mode);
        int r;
        r = srange(0, 99);
        if (mode == 0) return 0;
        if (mode == 1) begin
            if (r < 80) return 0;
            if (r < 97) return srange(1, 3);
            return srange(10, 40);
        end
        if (r < 40) return 0;
        if (r < 85) return srange(1, 4);
        if (r < 96) return srange(5, 12);
        return srange(20, 60);
    endfunction

    function automatic t_cfg reset_config();
        t_cfg c;
        c.junction_offset    = RST_JUNCTION_OFFSET;
        c.beat_period_ticks  = RST_BEAT_PERIOD_TICKS;
        c.stim_len_ticks     = RST_STIM_LEN_TICKS;
        c.stim_amplitude     = RST_STIM_AMPLITUDE;
        c.upstroke_threshold = RST_UPSTROKE_THRESHOLD;
        c.repol_percent      = RST_REPOL_PERCENT;
        c.stim_window_ticks  = RST_STIM_WINDOW_TICKS;
        c.peak_hold_ticks    = RST_PEAK_HOLD_TICKS;
        return c;
    endfunction

    // mostly settings under which beats get measured, with extremes mixed in
    function automatic t_cfg random_config();
        t_cfg c;
        if (srange(0, 7) == 0)
            c.junction_offset = srange(0, 1) ? 16'h8000 : 16'h7FFF;
        else
            c.junction_offset = 16'(srange(-500, 500));
        if (srange(0, 9) == 0) begin
            case (srange(0, 2))
                0:       c.beat_period_ticks = 20'd0;
                1:       c.beat_period_ticks = 20'd1;
                default: c.beat_period_ticks = 20'hFFFFF;
            endcase
        end else begin
            c.beat_period_ticks = 20'(srange(60, 300));
        end
        if (srange(0, 9) == 0)
            c.stim_len_ticks = srange(0, 1) ? 20'hFFFFF : 20'd0;
        else
            c.stim_len_ticks = 20'(srange(0, 20));
        c.stim_amplitude = 16'($urandom);
        if (srange(0, 9) == 0)
            c.upstroke_threshold = srange(0, 1) ? 16'h8000 : 16'h7FFF;
        else
            c.upstroke_threshold = 16'(srange(-5500, -2500));
        if (srange(0, 7) == 0) begin
            case (srange(0, 2))
                0:       c.repol_percent = 7'd0;
                1:       c.repol_percent = 7'd100;
                default: c.repol_percent = 7'd127;
            endcase
        end else begin
            c.repol_percent = 7'(srange(40, 110));
        end
        c.stim_window_ticks = (srange(0, 9) == 0) ? 20'hFFFFF : 20'(srange(0, 12));
        c.peak_hold_ticks   = (srange(0, 9) == 0) ? 20'hFFFFF : 20'(srange(0, 20));
        return c;
    endfunction

    // next voltage of the synthetic trace: rest, fast upstroke, drooping plateau,
    // linear repolarisation, rest again; some beats stay flat
    function automatic logic [15:0] next_ap_sample();
        int          v, top;
        logic [15:0] out;
        if (gen_pos == 0) begin
            ap_rest    = srange(-8300, -7700);
            ap_up      = srange(1, 4);
            ap_peak    = srange(500, 4000);
            ap_plateau = srange(5, gen_len / 4);
            ap_decay   = srange(5, gen_len / 3);
            ap_silent  = (srange(0, 7) == 0);
        end
        top = ap_peak - 3 * ap_plateau;
        if (ap_silent || gen_pos < ap_up)
            v = ap_rest + srange(-30, 30);
        else if (gen_pos < ap_up + 2)
            v = ap_rest + (ap_peak - ap_rest) * (gen_pos - ap_up + 1) / 3;
        else if (gen_pos < ap_up + 2 + ap_plateau)
            v = ap_peak - 3 * (gen_pos - ap_up - 2) + srange(-10, 10);
        else if (gen_pos < ap_up + 2 + ap_plateau + ap_decay)
            v = top - (top - ap_rest) * (gen_pos - ap_up - 2 - ap_plateau) / ap_decay;
        else
            v = ap_rest + srange(-30, 30);
        gen_pos++;
        if (gen_pos >= gen_len) gen_pos = 0;
        // the unit subtracts the offset, so add it back before clamping to the port
        out = 16'(sb.clamp16(v + int'($signed(cur_cfg.junction_offset))));
        return out;
    endfunction

    // offer one item, holding it until accepted; called and returns at a falling edge
    task automatic send_item(logic func, logic [15:0] raw);
        int gap;
        gap = pick_gap(tx_mode);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_func           = func;
        i_voltage_sample = raw;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(func, raw);
        @(negedge i_clk);
    endtask

    // valid stays high across back-to-back writes; write_config lowers it
    task automatic write_reg(logic [2:0] idx, logic [19:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // every register in turn, junk in the unused upper data bits
    task automatic write_config(t_cfg c);
        write_reg(REG_JUNCTION_OFFSET,    {4'($urandom), c.junction_offset});
        write_reg(REG_BEAT_PERIOD_TICKS,  c.beat_period_ticks);
        write_reg(REG_STIM_LEN_TICKS,     c.stim_len_ticks);
        write_reg(REG_STIM_AMPLITUDE,     {4'($urandom), c.stim_amplitude});
        write_reg(REG_UPSTROKE_THRESHOLD, {4'($urandom), c.upstroke_threshold});
        write_reg(REG_REPOL_PERCENT,      {13'($urandom), c.repol_percent});
        write_reg(REG_STIM_WINDOW_TICKS,  c.stim_window_ticks);
        write_reg(REG_PEAK_HOLD_TICKS,    c.peak_hold_ticks);
        i_cfg_valid = 1'b0;
        cur_cfg = c;
        if (c.beat_period_ticks >= 20'd30 && c.beat_period_ticks <= 20'd400)
            gen_len = int'(c.beat_period_ticks);
        else
            gen_len = 150;
        gen_pos = 0;
    endtask

    // stop offering, wait for every expected result, then let the pipe settle
    task automatic wait_idle();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one random phase: a restart to line the trace up with the beat, then mostly
    // shaped beats with some full-range noise and the odd restart
    task automatic run_phase(int n);
        int          r;
        logic [15:0] v;
        gen_pos = 0;
        send_item(FUNC_RESTART, 16'($urandom));
        for (int k = 1; k < n; k++) begin
            if (k % 40 == 0) tx_mode = srange(0, 2);
            r = srange(0, 199);
            if (r == 0) begin
                gen_pos = 0;
                send_item(FUNC_RESTART, 16'($urandom));
            end else begin
                v = next_ap_sample();
                if (r < 16) v = 16'($urandom);
                send_item(FUNC_TICK, v);
            end
        end
    endtask

    // result side: accept and check on the rising edge
    always @(posedge i_clk) begin : collect_readout
        apd_result_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.stim_current     = o_stim_current;
            got.stim_active      = o_stim_active;
            got.beat_count       = o_beat_count;
            got.apd_ticks        = o_apd_ticks;
            got.measure_phase    = o_measure_phase;
            got.membrane_voltage = o_membrane_voltage;
            sb.check_readout(got);
        end
    end

    // receiver ready: random stalls, stall-free stretches, one long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && sb.samples_noted >= PRESSURE_AT) begin
                pressure_left = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (pressure_left > 0) begin
                i_ready = 1'b0;
                pressure_left--;
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready = 1'b1;
                stall_left = pick_gap(rx_mode);
            end
            rx_cycles++;
            if (rx_cycles % 64 == 0) rx_mode = srange(0, 2);
        end
    end

    // watchdog: any handshake clears it
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        sb               = new();
        cur_cfg          = reset_config();
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_func           = FUNC_TICK;
        i_voltage_sample = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // short beat, full amplitude, 100 percent repolarisation, no window or hold:
        // upstroke exactly at threshold, peak, repol level, apd end, done holds
        c = reset_config();
        c.beat_period_ticks = 20'd30;
        c.stim_len_ticks    = 20'd3;
        c.stim_amplitude    = 16'hFFFF;
        c.repol_percent     = 7'd100;
        c.stim_window_ticks = 20'd0;
        c.peak_hold_ticks   = 20'd0;
        write_config(c);
        send_item(FUNC_RESTART, -16'sd8000);
        send_item(FUNC_TICK, -16'sd4000);
        send_item(FUNC_TICK, 16'h7FFF);
        send_item(FUNC_TICK, 16'h7FFF);
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_TICK, -16'sd8000);
        send_item(FUNC_TICK, 16'h8000);
        send_item(FUNC_RESTART, 16'sd12345);

        // percent above hundred from full-scale rest to full-scale peak:
        // repol level saturates low, longest period, stimulus never on
        wait_idle();
        c = reset_config();
        c.beat_period_ticks  = 20'hFFFFF;
        c.stim_len_ticks     = 20'd0;
        c.stim_amplitude     = 16'd0;
        c.upstroke_threshold = 16'h8000;
        c.repol_percent      = 7'd127;
        c.stim_window_ticks  = 20'd0;
        c.peak_hold_ticks    = 20'd0;
        write_config(c);
        send_item(FUNC_RESTART, 16'h8000);
        send_item(FUNC_TICK, 16'h7FFF);
        send_item(FUNC_TICK, 16'h7FFF);
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_TICK, 16'h8000);

        // zero beat period (a beat every tick), offset at both extremes so the
        // corrected voltage saturates both ways, longest stimulus and windows
        wait_idle();
        c = reset_config();
        c.junction_offset    = 16'h8000;
        c.beat_period_ticks  = 20'd0;
        c.stim_len_ticks     = 20'hFFFFF;
        c.stim_amplitude     = 16'h8001;
        c.upstroke_threshold = 16'h7FFF;
        c.repol_percent      = 7'd0;
        c.stim_window_ticks  = 20'hFFFFF;
        c.peak_hold_ticks    = 20'hFFFFF;
        write_config(c);
        send_item(FUNC_TICK, 16'h7FFF);
        send_item(FUNC_TICK, 16'h8000);
        send_item(FUNC_TICK, 16'h0000);
        send_item(FUNC_RESTART, 16'h7FFF);
        wait_idle();
        c.junction_offset = 16'h7FFF;
        write_config(c);
        send_item(FUNC_TICK, 16'h8000);
        send_item(FUNC_TICK, 16'h7FFF);
        send_item(FUNC_TICK, 16'hFFFF);

        // random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_config(random_config());
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (sb.fault_count == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/pwam_pkg.sv
hdl/pwam_cfg.sv
hdl/pwam_pacer.sv
hdl/pwam_apd.sv
hdl/pacer_with_apd_measure_unit.sv
verif/pacer_with_apd_measure_unit_tb.sv
